>>> rtl/symbol_vocabulary_table_defines.svh
// ----------------------------------------------------------------------------
// symbol vocabulary table assertion macros
// concurrent checks, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef SYMBOL_VOCABULARY_TABLE_DEFINES_SVH
`define SYMBOL_VOCABULARY_TABLE_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define SVT_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("symbol vocabulary table check failed");

// next-cycle implication
`define SVT_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("symbol vocabulary table check failed");

`else

`define SVT_ASSERT_IMP(label, ante, cons)
`define SVT_ASSERT_NXT(label, ante, cons)

`endif

`endif

>>> rtl/svt_pkg.sv
// ----------------------------------------------------------------------------
// svt_pkg
// types and codes shared by the symbol vocabulary table
// ----------------------------------------------------------------------------
package svt_pkg;

    localparam int ENTRIES_DEFAULT = 128;
    localparam int SYM_W           = 8;
    localparam int SLOT_W          = 8;
    localparam int OCC_W           = 9;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_READ   = 2'd2
    } op_e;

    typedef enum logic [1:0] {
        ST_FOUND = 2'd0,
        ST_NEW   = 2'd1,
        ST_MISS  = 2'd2,
        ST_RANGE = 2'd3
    } status_e;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_READ,
        S_RDATA,
        S_DONE
    } state_e;

    typedef struct packed {
        logic [1:0]        op;
        logic [SYM_W-1:0]  symbol;
        logic [SLOT_W-1:0] slot;
    } req_t;

    typedef struct packed {
        logic [SLOT_W-1:0] found_index;
        logic [SYM_W-1:0]  found_symbol;
        logic [1:0]        status;
        logic [OCC_W-1:0]  occupied;
    } rsp_t;

endpackage

>>> rtl/symbol_vocabulary_table.sv
// ----------------------------------------------------------------------------
// symbol_vocabulary_table
// vocabulary of distinct byte symbols held in one entry memory
// ----------------------------------------------------------------------------
// Usage: requests enter on req (valid/ready), one result per item leaves on
// rsp (valid/ready). Op insert returns the slot of a symbol already held or
// stores it at the next free slot while one is left; op lookup searches the
// occupied slots; op read returns the symbol at a slot. Every result carries
// the occupied count after the item.
// One item is worked on at a time. Insert and lookup scan the entry memory
// one slot a cycle from slot 0 and stop at a hit or at the last occupied
// slot; an empty table answers without a scan. A read goes through the
// memory, but a slot that is out of range or not yet occupied is answered
// without touching the memory. The next item can be accepted in the same
// cycle that rsp valid rises.
// Reset clears the occupied count; slots at or above the count read as 0,
// so no clearing pass is needed. A result waits in the output register while
// the receiver stalls; the next item is still accepted and worked on, and
// its result waits until the output register frees up.
// ----------------------------------------------------------------------------
`include "symbol_vocabulary_table_defines.svh"

module symbol_vocabulary_table #(
    parameter int ENTRIES = svt_pkg::ENTRIES_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  svt_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output svt_pkg::rsp_t rsp
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);

    svt_pkg::state_e state_reg, state_next;
    svt_pkg::req_t   item_reg;
    svt_pkg::req_t   cur;
    svt_pkg::rsp_t   pend_reg, res;
    svt_pkg::rsp_t   rsp_reg;
    logic            rsp_valid_reg;

    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [CNT_W-1:0] issue_reg;
    logic             cmp_valid_reg;
    logic [IDX_W-1:0] cmp_addr_reg;

    logic [svt_pkg::SYM_W-1:0] mem [ENTRIES];
    logic [svt_pkg::SYM_W-1:0] rd_data_reg;
    logic [IDX_W-1:0]          rd_addr;
    logic                      wr_en;

    logic direct;
    logic hit;
    logic scan_last;
    logic fin;
    logic ins_new;
    logic in_range;
    logic out_free;

    // ------------------------------------------------------------------
    // entry memory: one write, one registered read
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[fill_reg[IDX_W-1:0]] <= cur.symbol;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign cur      = (state_reg == svt_pkg::S_IDLE) ? req : item_reg;
    assign out_free = !rsp_valid_reg || rsp_ready;
    assign in_range = {1'b0, cur.slot} < 9'(ENTRIES);

    // item finishes without touching the memory
    always_comb
    begin
        unique case (cur.op) inside
            svt_pkg::OP_READ:   direct = !(9'(cur.slot) < 9'(fill_reg));
            svt_pkg::OP_INSERT,
            svt_pkg::OP_LOOKUP: direct = (fill_reg == '0);
            default:            direct = 1'b1;
        endcase
    end

    // ------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            svt_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    if (direct)
                    begin
                        state_next = svt_pkg::S_DONE;
                    end
                    else if (req.op == svt_pkg::OP_READ)
                    begin
                        state_next = svt_pkg::S_READ;
                    end
                    else
                    begin
                        state_next = svt_pkg::S_SCAN;
                    end
                end
            end
            svt_pkg::S_SCAN:
            begin
                if (fin)
                begin
                    state_next = svt_pkg::S_DONE;
                end
            end
            svt_pkg::S_READ:  state_next = svt_pkg::S_RDATA;
            svt_pkg::S_RDATA: state_next = svt_pkg::S_DONE;
            svt_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    state_next = svt_pkg::S_IDLE;
                end
            end
            default: state_next = svt_pkg::S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // outputs: handshake, read address, finish and result
    // ------------------------------------------------------------------
    always_comb
    begin
        req_ready = (state_reg == svt_pkg::S_IDLE);
        rd_addr   = issue_reg[IDX_W-1:0];
        if (state_reg == svt_pkg::S_READ)
        begin
            rd_addr = item_reg.slot[IDX_W-1:0];
        end

        hit       = (state_reg == svt_pkg::S_SCAN) && cmp_valid_reg
                    && (rd_data_reg == item_reg.symbol);
        scan_last = cmp_valid_reg && ((CNT_W'(cmp_addr_reg) + 1'b1) == fill_reg);

        fin = ((state_reg == svt_pkg::S_IDLE) && req_valid && direct)
              || ((state_reg == svt_pkg::S_SCAN) && (hit || scan_last))
              || (state_reg == svt_pkg::S_RDATA);

        res        = '0;
        res.status = svt_pkg::ST_MISS;
        ins_new    = 1'b0;
        unique case (cur.op)
            svt_pkg::OP_INSERT:
            begin
                if (hit)
                begin
                    res.found_index = 8'(cmp_addr_reg);
                    res.status      = svt_pkg::ST_FOUND;
                end
                else if (fill_reg < CNT_W'(ENTRIES))
                begin
                    res.found_index = 8'(fill_reg);
                    res.status      = svt_pkg::ST_NEW;
                    ins_new         = 1'b1;
                end
            end
            svt_pkg::OP_LOOKUP:
            begin
                if (hit)
                begin
                    res.found_index = 8'(cmp_addr_reg);
                    res.status      = svt_pkg::ST_FOUND;
                end
            end
            svt_pkg::OP_READ:
            begin
                if (!in_range)
                begin
                    res.status = svt_pkg::ST_RANGE;
                end
                else
                begin
                    res.status = svt_pkg::ST_FOUND;
                    if (state_reg == svt_pkg::S_RDATA)
                    begin
                        res.found_symbol = rd_data_reg;
                    end
                end
            end
            default: res.status = svt_pkg::ST_MISS;
        endcase

        wr_en        = fin && ins_new;
        fill_next    = fill_reg + CNT_W'(wr_en);
        res.occupied = 9'(fill_next);
    end

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= svt_pkg::S_IDLE;
            fill_reg      <= '0;
            issue_reg     <= '0;
            cmp_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;

            if (state_reg == svt_pkg::S_SCAN)
            begin
                if (issue_reg < fill_reg)
                begin
                    issue_reg <= issue_reg + 1'b1;
                end
                cmp_valid_reg <= (issue_reg < fill_reg) && !fin;
            end
            else
            begin
                issue_reg     <= '0;
                cmp_valid_reg <= 1'b0;
            end

            if (state_reg == svt_pkg::S_DONE && out_free)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            item_reg <= req;
        end
        cmp_addr_reg <= issue_reg[IDX_W-1:0];
        if (fin)
        begin
            pend_reg <= res;
        end
        if (state_reg == svt_pkg::S_DONE && out_free)
        begin
            rsp_reg <= pend_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    `SVT_ASSERT_NXT(a_fill_step, wr_en, fill_reg == CNT_W'($past(fill_reg) + 1'b1))
    `SVT_ASSERT_IMP(a_cmp_in_fill, cmp_valid_reg, CNT_W'(cmp_addr_reg) < fill_reg)
    `SVT_ASSERT_NXT(a_done_out, state_reg == svt_pkg::S_DONE && out_free, rsp_valid && state_reg == svt_pkg::S_IDLE)

endmodule

>>> tb/tb_symbol_vocabulary_table.sv
// ----------------------------------------------------------------------------
// tb_symbol_vocabulary_table
// checks inserts, lookups and slot reads of the symbol vocabulary table
// ----------------------------------------------------------------------------
// A short table of directed items runs first on the empty table. Some rows
// carry the expected result typed in and the others go to the predictor. A
// long random run follows, in four phases of sender and receiver idling. It
// fills the table to the top and keeps going on the full table. Every result
// is compared field by field with the oldest expected result.
// ----------------------------------------------------------------------------
module tb_symbol_vocabulary_table;

    localparam int ENTRIES          = svt_pkg::ENTRIES_DEFAULT;
    localparam int RANDOM_PER_PHASE = 482;
    localparam int STALL_LIMIT      = 20 * (ENTRIES + 8);
    localparam int TAIL_CYCLES      = ENTRIES + 16;
    localparam int PRINT_CAP        = 100;

    // op code that the package leaves unnamed
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct {
        svt_pkg::req_t item;
        bit            typed;
        svt_pkg::rsp_t want;
    } stim_row_t;

    logic          clk       = 1'b0;
    logic          rst_n     = 1'b0;
    logic          req_valid = 1'b0;
    logic          req_ready;
    svt_pkg::req_t req       = '0;
    logic          rsp_valid;
    logic          rsp_ready = 1'b0;
    svt_pkg::rsp_t rsp;

    // predictor state: copy of the entry memory and the fill count
    logic [svt_pkg::SYM_W-1:0] vocab_sym [ENTRIES];
    int                        vocab_fill;

    svt_pkg::rsp_t vocab_results_q [$];
    stim_row_t     directed_rows [$];

    int err_count     = 0;
    int idle_cycles   = 0;
    int send_idle_pct = 0;
    int stall_pct     = 0;

    symbol_vocabulary_table #(
        .ENTRIES(ENTRIES)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp(rsp)
    );

    initial
    begin
        forever
        begin
            #1 clk = ~clk;
        end
    end

    function automatic svt_pkg::rsp_t vocab_predict(input svt_pkg::req_t item);
        svt_pkg::rsp_t r;
        int            hit;
        r = '0;
        r.status = svt_pkg::ST_MISS;
        hit = -1;
        for (int i = 0; i < vocab_fill; i++)
        begin
            if (hit < 0 && vocab_sym[i] == item.symbol)
                hit = i;
        end
        case (item.op)
            svt_pkg::OP_INSERT:
            begin
                if (hit >= 0)
                begin
                    r.found_index = 8'(hit);
                    r.status = svt_pkg::ST_FOUND;
                end
                else if (vocab_fill < ENTRIES)
                begin
                    vocab_sym[vocab_fill] = item.symbol;
                    r.found_index = 8'(vocab_fill);
                    r.status = svt_pkg::ST_NEW;
                    vocab_fill++;
                end
            end
            svt_pkg::OP_LOOKUP:
            begin
                if (hit >= 0)
                begin
                    r.found_index = 8'(hit);
                    r.status = svt_pkg::ST_FOUND;
                end
            end
            svt_pkg::OP_READ:
            begin
                if (item.slot < ENTRIES)
                begin
                    r.found_symbol = vocab_sym[item.slot];
                    r.status = svt_pkg::ST_FOUND;
                end
                else
                    r.status = svt_pkg::ST_RANGE;
            end
            default:
            begin
            end
        endcase
        r.occupied = 9'(vocab_fill);
        return r;
    endfunction

    // mostly inserts and lookups, lookups and reads aimed at held entries half the time
    function automatic svt_pkg::req_t random_item();
        svt_pkg::req_t item;
        int            pick;
        item.symbol = 8'($urandom_range(0, 255));
        item.slot = 8'($urandom_range(0, 255));
        pick = $urandom_range(0, 99);
        if (pick < 35)
            item.op = svt_pkg::OP_INSERT;
        else if (pick < 65)
        begin
            item.op = svt_pkg::OP_LOOKUP;
            if (vocab_fill > 0 && $urandom_range(0, 1) == 1)
                item.symbol = vocab_sym[$urandom_range(0, vocab_fill - 1)];
        end
        else if (pick < 95)
        begin
            item.op = svt_pkg::OP_READ;
            if (vocab_fill > 0 && $urandom_range(0, 1) == 1)
                item.slot = 8'($urandom_range(0, vocab_fill - 1));
        end
        else
            item.op = OP_UNUSED;
        return item;
    endfunction

    task automatic add_row(input logic [1:0] op, input logic [svt_pkg::SYM_W-1:0] symbol,
                           input logic [svt_pkg::SLOT_W-1:0] slot, input bit typed,
                           input logic [svt_pkg::SLOT_W-1:0] idx,
                           input logic [svt_pkg::SYM_W-1:0] sym_out,
                           input svt_pkg::status_e status,
                           input logic [svt_pkg::OCC_W-1:0] occupied);
        stim_row_t row;
        row.item.op = op;
        row.item.symbol = symbol;
        row.item.slot = slot;
        row.typed = typed;
        row.want.found_index = idx;
        row.want.found_symbol = sym_out;
        row.want.status = status;
        row.want.occupied = occupied;
        directed_rows.push_back(row);
    endtask

    task automatic report_mismatch(input string msg);
        if (err_count < PRINT_CAP)
            $display("%0t mismatch: %s", $time, msg);
        err_count++;
    endtask

    task automatic check_result(input svt_pkg::rsp_t got, input svt_pkg::rsp_t want);
        if (got.found_index !== want.found_index)
            report_mismatch($sformatf("found_index %0d, expected %0d",
                                      got.found_index, want.found_index));
        if (got.found_symbol !== want.found_symbol)
            report_mismatch($sformatf("found_symbol %0d, expected %0d",
                                      got.found_symbol, want.found_symbol));
        if (got.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d",
                                      got.status, want.status));
        if (got.occupied !== want.occupied)
            report_mismatch($sformatf("occupied %0d, expected %0d",
                                      got.occupied, want.occupied));
    endtask

    // drives one item and records its expected result once accepted
    task automatic send_item(input svt_pkg::req_t item, input bit typed,
                             input svt_pkg::rsp_t typed_rsp);
        svt_pkg::rsp_t predicted;
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct)
                @(posedge clk);
        end
        req <= item;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        predicted = vocab_predict(item);
        vocab_results_q.push_back(typed ? typed_rsp : predicted);
    endtask

    task automatic wait_all_results();
        req_valid <= 1'b0;
        while (vocab_results_q.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        svt_pkg::rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (vocab_results_q.size() == 0)
                report_mismatch("result with no item waiting");
            else
            begin
                want = vocab_results_q.pop_front();
                check_result(rsp, want);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("tb_symbol_vocabulary_table: errors");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < ENTRIES; i++)
            vocab_sym[i] = '0;
        vocab_fill = 0;

        // empty table: cleared slots, range edges, misses and the unused op
        add_row(svt_pkg::OP_READ,   8'h00, 8'd0,  1, 8'd0, 8'h00, svt_pkg::ST_FOUND, 9'd0);
        add_row(svt_pkg::OP_READ,   8'hFF, 8'd255, 1, 8'd0, 8'h00, svt_pkg::ST_RANGE, 9'd0);
        add_row(svt_pkg::OP_READ,   8'h00, 8'(ENTRIES), 1, 8'd0, 8'h00,
                svt_pkg::ST_RANGE, 9'd0);
        add_row(svt_pkg::OP_READ,   8'h00, 8'(ENTRIES - 1), 1, 8'd0, 8'h00,
                svt_pkg::ST_FOUND, 9'd0);
        add_row(svt_pkg::OP_LOOKUP, 8'h00, 8'h00, 1, 8'd0, 8'h00, svt_pkg::ST_MISS,  9'd0);
        add_row(OP_UNUSED,          8'hFF, 8'hFF, 1, 8'd0, 8'h00, svt_pkg::ST_MISS,  9'd0);
        // symbol extremes go in, then get found again
        add_row(svt_pkg::OP_INSERT, 8'hFF, 8'h00, 1, 8'd0, 8'h00, svt_pkg::ST_NEW,   9'd1);
        add_row(svt_pkg::OP_INSERT, 8'h00, 8'hFF, 1, 8'd1, 8'h00, svt_pkg::ST_NEW,   9'd2);
        add_row(svt_pkg::OP_INSERT, 8'hFF, 8'h55, 1, 8'd0, 8'h00, svt_pkg::ST_FOUND, 9'd2);
        add_row(svt_pkg::OP_LOOKUP, 8'h00, 8'hAA, 1, 8'd1, 8'h00, svt_pkg::ST_FOUND, 9'd2);
        add_row(svt_pkg::OP_LOOKUP, 8'hFF, 8'h00, 1, 8'd0, 8'h00, svt_pkg::ST_FOUND, 9'd2);
        add_row(svt_pkg::OP_READ,   8'h00, 8'd0,  1, 8'd0, 8'hFF, svt_pkg::ST_FOUND, 9'd2);
        add_row(svt_pkg::OP_READ,   8'hFF, 8'd1,  1, 8'd0, 8'h00, svt_pkg::ST_FOUND, 9'd2);
        add_row(svt_pkg::OP_READ,   8'hFF, 8'd2,  1, 8'd0, 8'h00, svt_pkg::ST_FOUND, 9'd2);
        add_row(svt_pkg::OP_INSERT, 8'hA5, 8'h5A, 0, 8'd0, 8'h00, svt_pkg::ST_FOUND, 9'd0);
        add_row(svt_pkg::OP_INSERT, 8'h5A, 8'hA5, 0, 8'd0, 8'h00, svt_pkg::ST_FOUND, 9'd0);
        add_row(svt_pkg::OP_LOOKUP, 8'h5A, 8'h00, 0, 8'd0, 8'h00, svt_pkg::ST_FOUND, 9'd0);
        add_row(svt_pkg::OP_LOOKUP, 8'h01, 8'hFF, 0, 8'd0, 8'h00, svt_pkg::ST_FOUND, 9'd0);
        add_row(svt_pkg::OP_READ,   8'h00, 8'd3,  0, 8'd0, 8'h00, svt_pkg::ST_FOUND, 9'd0);
        add_row(svt_pkg::OP_READ,   8'h00, 8'd127, 0, 8'd0, 8'h00, svt_pkg::ST_FOUND, 9'd0);
        add_row(OP_UNUSED,          8'h00, 8'h00, 0, 8'd0, 8'h00, svt_pkg::ST_FOUND, 9'd0);
        add_row(svt_pkg::OP_INSERT, 8'h80, 8'h7F, 0, 8'd0, 8'h00, svt_pkg::ST_FOUND, 9'd0);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);

        // idling phases; the table fills up part way through and stays full
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 64;
                    stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct = 64;
                end
                default:
                begin
                    send_idle_pct = 11;
                    stall_pct = 11;
                end
            endcase
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
                send_item(random_item(), 1'b0, '0);
            // sender holds off until the block has answered everything
            wait_all_results();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("tb_symbol_vocabulary_table: clean");
        else
            $display("tb_symbol_vocabulary_table: errors");
        $finish;
    end

endmodule

>>> symbol_vocabulary_table.f
+incdir+rtl
rtl/svt_pkg.sv
rtl/symbol_vocabulary_table.sv
tb/tb_symbol_vocabulary_table.sv
